// ===== rtl/core/lcsp_pkg.sv =====
// shared types, codes and gain table helper for the looped cubic sample player
package lcsp_pkg;

   typedef enum logic [1:0] {
      OP_LOAD   = 2'd0,
      OP_NOTE   = 2'd1,
      OP_RENDER = 2'd2,
      OP_UNUSED = 2'd3
   } op_type;

   typedef enum logic [2:0] {
      CSR_LOOP_ENABLE   = 3'd0,
      CSR_LOOP_START    = 3'd1,
      CSR_LOOP_END      = 3'd2,
      CSR_CROSSFADE_LEN = 3'd3,
      CSR_SAMPLE_COUNT  = 3'd4,
      CSR_STEREO        = 3'd5
   } csr_index_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SETUP,
      ST_FETCH,
      ST_HORNER,
      ST_WAITDIV,
      ST_BLEND,
      ST_WRITE
   } state_type;

   localparam int CSR_IDX_BITS  = 3;
   localparam int CSR_DATA_BITS = 17;
   localparam int GAIN_BITS     = 17;
   localparam logic [GAIN_BITS-1:0] UNITY_GAIN = 17'd32768;
   localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

   typedef struct packed {
      logic       load;
      logic       note;
      logic       render;
      logic       div_start;
      logic       rd_en;
      logic       alt;
      logic [1:0] tap;
      logic       cap_en;
      logic [1:0] cap_tap;
      logic       hor_en;
      logic       hor_ch;
      logic [1:0] hor_step;
      logic       blend_en;
      logic [1:0] blend_step;
      logic       out_load;
   } ctrl_type;

   typedef struct packed {
      logic fade;
      logic div_busy;
   } status_type;

   // quarter sine in q15 from a q30 angle, taylor series to x^11
   function automatic logic [GAIN_BITS-1:0] quarter_sine(input logic [63:0] x);
      logic [63:0] x2;
      logic [63:0] t;
      logic [63:0] r;
      logic signed [64:0] s;
      x2 = (x * x) >> 30;
      t  = x;
      s  = signed'({1'b0, x});
      t  = ((t * x2) >> 30) / 64'd6;
      s  = s - signed'({1'b0, t});
      t  = ((t * x2) >> 30) / 64'd20;
      s  = s + signed'({1'b0, t});
      t  = ((t * x2) >> 30) / 64'd42;
      s  = s - signed'({1'b0, t});
      t  = ((t * x2) >> 30) / 64'd72;
      s  = s + signed'({1'b0, t});
      t  = ((t * x2) >> 30) / 64'd110;
      s  = s - signed'({1'b0, t});
      if (s < 0) begin
         s = '0;
      end
      r = (s[63:0] + 64'd16384) >> 15;
      if (r > 64'(UNITY_GAIN)) begin
         r = 64'(UNITY_GAIN);
      end
      return r[GAIN_BITS-1:0];
   endfunction

endpackage

// ===== rtl/core/looped_cubic_sample_playback.sv =====
// looped cubic sample playback: top level
// load and note-start words are accepted back to back, with no result
// render words hold off input until the result is written, and in the crossfade zone
// make a second four-tap fetch and horner pass through the shared multiplier
// one render is worked at a time; the result sits in an output register
// synchronous active-high reset clears controller, position and config; memory keeps
module looped_cubic_sample_playback
   import lcsp_pkg::*;
#(
   parameter int ADDR_BITS        = 16,
   parameter int SAMPLE_BITS      = 16,
   parameter int FRAC_BITS        = 16,
   parameter int SINE_TABLE_DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic [1:0]               req_operation,
   input  logic [15:0]              req_address,
   input  logic signed [15:0]       req_left_in,
   input  logic signed [15:0]       req_right_in,
   input  logic [19:0]              req_step,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic signed [15:0]       rsp_left_out,
   output logic signed [15:0]       rsp_right_out,
   output logic                     rsp_in_crossfade,
   input  logic                     csr_valid,
   output logic                     csr_ready,
   input  logic [CSR_IDX_BITS-1:0]  csr_index,
   input  logic [CSR_DATA_BITS-1:0] csr_wdata
);
   ctrl_type   cmd;
   status_type st;

   assign csr_ready = 1'b1;

   lcsp_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_operation (req_operation),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .st            (st),
      .cmd           (cmd)
   );

   lcsp_dp #(
      .ADDR_BITS        (ADDR_BITS),
      .SAMPLE_BITS      (SAMPLE_BITS),
      .FRAC_BITS        (FRAC_BITS),
      .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .st               (st),
      .req_address      (req_address),
      .req_left_in      (req_left_in),
      .req_right_in     (req_right_in),
      .req_step         (req_step),
      .csr_we           (csr_valid & csr_ready),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .rsp_left_out     (rsp_left_out),
      .rsp_right_out    (rsp_right_out),
      .rsp_in_crossfade (rsp_in_crossfade)
   );
endmodule

// ===== rtl/core/lcsp_ram.sv =====
// generic single-write ram with registered read
module lcsp_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 65536
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem [0:DEPTH-1];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;
endmodule

// ===== rtl/core/lcsp_ctrl.sv =====
// sequencer for load, note start and render words
module lcsp_ctrl
   import lcsp_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [1:0] req_operation,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   input  status_type st,
   output ctrl_type   cmd
);
   state_type  state_ff, state_in;
   logic [2:0] cnt_ff, cnt_in;
   logic       pass_ff, pass_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic [2:0] cap_m1;
   logic [2:0] ch_m3;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         pass_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         pass_ff      <= pass_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign cap_m1 = cnt_ff - 3'd1;
   assign ch_m3  = cnt_ff - 3'd3;

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      pass_in      = pass_ff;
      rsp_valid_in = rsp_valid_ff;
      cmd          = '0;
      cmd.alt      = pass_ff;
      req_stall    = 1'b1;
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
      unique case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               unique case (op_type'(req_operation))
                  OP_LOAD:   cmd.load = 1'b1;
                  OP_NOTE:   cmd.note = 1'b1;
                  OP_RENDER: begin
                     cmd.render = 1'b1;
                     state_in   = ST_SETUP;
                  end
                  default: ;
               endcase
            end
         end
         ST_SETUP: begin
            cmd.div_start = 1'b1;
            pass_in       = 1'b0;
            cnt_in        = '0;
            state_in      = ST_FETCH;
         end
         ST_FETCH: begin
            // four taps issued, each tap's data is captured in the cycle after its read
            cmd.rd_en   = (cnt_ff != 3'd4);
            cmd.tap     = cnt_ff[1:0];
            cmd.cap_en  = (cnt_ff != 3'd0);
            cmd.cap_tap = cap_m1[1:0];
            if (cnt_ff == 3'd4) begin
               cnt_in   = '0;
               state_in = ST_HORNER;
            end else begin
               cnt_in = cnt_ff + 3'd1;
            end
         end
         ST_HORNER: begin
            cmd.hor_en   = 1'b1;
            cmd.hor_ch   = (cnt_ff >= 3'd3);
            cmd.hor_step = (cnt_ff >= 3'd3) ? ch_m3[1:0] : cnt_ff[1:0];
            if (cnt_ff == 3'd5) begin
               cnt_in = '0;
               if (!pass_ff && st.fade) begin
                  pass_in  = 1'b1;
                  state_in = ST_FETCH;
               end else begin
                  state_in = ST_WAITDIV;
               end
            end else begin
               cnt_in = cnt_ff + 3'd1;
            end
         end
         ST_WAITDIV: begin
            if (!st.div_busy) begin
               cnt_in   = '0;
               state_in = ST_BLEND;
            end
         end
         ST_BLEND: begin
            cmd.blend_en   = 1'b1;
            cmd.blend_step = cnt_ff[1:0];
            if (cnt_ff == 3'd3) begin
               state_in = ST_WRITE;
            end
            cnt_in = cnt_ff + 3'd1;
         end
         ST_WRITE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               cmd.out_load = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign rsp_valid = rsp_valid_ff;
endmodule

// ===== rtl/core/lcsp_dp.sv =====
// datapath: registers, sample memories, interpolator, gain divider and mixer
module lcsp_dp
   import lcsp_pkg::*;
#(
   parameter int ADDR_BITS        = 16,
   parameter int SAMPLE_BITS      = 16,
   parameter int FRAC_BITS        = 16,
   parameter int SINE_TABLE_DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     reset,
   input  ctrl_type                 cmd,
   output status_type               st,
   input  logic [15:0]              req_address,
   input  logic signed [15:0]       req_left_in,
   input  logic signed [15:0]       req_right_in,
   input  logic [19:0]              req_step,
   input  logic                     csr_we,
   input  logic [CSR_IDX_BITS-1:0]  csr_index,
   input  logic [CSR_DATA_BITS-1:0] csr_wdata,
   output logic signed [15:0]       rsp_left_out,
   output logic signed [15:0]       rsp_right_out,
   output logic                     rsp_in_crossfade
);
   localparam int AB   = ADDR_BITS;
   localparam int SB   = SAMPLE_BITS;
   localparam int F    = FRAC_BITS;
   localparam int PW   = AB + F;
   localparam int W    = SB + 6;
   localparam int MBW  = (F + 1 > 18) ? F + 1 : 18;
   localparam int PRW  = W + MBW;
   localparam int SUMW = PRW + 1;
   localparam int IW   = $clog2(SINE_TABLE_DEPTH + 1);
   localparam int DCW  = $clog2(IW + 1);
   localparam int LCW  = (AB + 1 > 17) ? AB + 1 : 17;
   localparam int XW   = (AB > 15) ? AB : 15;
   localparam int SPW  = 15 + F;
   localparam int NW   = SPW + IW;
   localparam int OW   = (PW > SPW) ? PW : SPW;
   localparam int FSW  = F + 4;
   localparam logic [LCW-1:0] MEM_WORDS = LCW'(1) << AB;
   localparam logic [PW-1:0]  POS_MAX   = '1;
   localparam logic [IW-1:0]  TAB_TOP   = IW'(SINE_TABLE_DEPTH);
   localparam logic signed [SUMW:0] SAT_HI = 32767;
   localparam logic signed [SUMW:0] SAT_LO = -32768;

   // configuration registers
   logic          loop_enable_ff;
   logic [15:0]   loop_start_ff;
   logic [15:0]   loop_end_ff;
   logic [14:0]   crossfade_len_ff;
   logic [16:0]   sample_count_ff;
   logic          stereo_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         loop_enable_ff   <= 1'b0;
         loop_start_ff    <= 16'd0;
         loop_end_ff      <= 16'hffff;
         crossfade_len_ff <= 15'd882;
         sample_count_ff  <= 17'h10000;
         stereo_ff        <= 1'b1;
      end else if (csr_we) begin
         case (csr_index_type'(csr_index))
            CSR_LOOP_ENABLE:   loop_enable_ff   <= csr_wdata[0];
            CSR_LOOP_START:    loop_start_ff    <= csr_wdata[15:0];
            CSR_LOOP_END:      loop_end_ff      <= csr_wdata[15:0];
            CSR_CROSSFADE_LEN: crossfade_len_ff <= csr_wdata[14:0];
            CSR_SAMPLE_COUNT:  sample_count_ff  <= csr_wdata;
            CSR_STEREO:        stereo_ff        <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // live sample count and last index
   logic [LCW-1:0] live_cnt;
   logic [LCW-1:0] live_m1;
   logic [AB-1:0]  last_idx;
   always_comb begin
      live_cnt = LCW'(sample_count_ff);
      if (sample_count_ff == 17'd0) begin
         live_cnt = LCW'(1);
      end else if (LCW'(sample_count_ff) > MEM_WORDS) begin
         live_cnt = MEM_WORDS;
      end
      live_m1  = live_cnt - LCW'(1);
      last_idx = live_m1[AB-1:0];
   end

   // note start: latch loop bounds
   logic [AB-1:0] note_s, note_e, note_lim;
   logic [14:0]   note_cf;
   logic [AB-1:0] note_diff;
   always_comb begin
      note_s = (LCW'(loop_start_ff) > LCW'(last_idx)) ? last_idx
             : loop_start_ff[AB-1:0];
      note_e = (LCW'(loop_end_ff) > LCW'(last_idx)) ? last_idx
             : loop_end_ff[AB-1:0];
      if (note_e <= note_s) begin
         note_e = last_idx;
      end
      note_diff = note_e - note_s;
      note_lim  = note_diff >> 1;
      note_cf   = (XW'(crossfade_len_ff) > XW'(note_lim)) ? note_lim[14:0]
                : crossfade_len_ff;
   end

   logic [PW-1:0] pos_ff;
   logic [AB-1:0] act_end_ff;
   logic [14:0]   act_cf_ff;
   logic [AB-1:0] held_start_ff;
   logic          held_en_ff;

   // render setup
   logic [XW-1:0]  zone_x;
   logic [PW-1:0]  zone_pos;
   logic [PW-1:0]  end_pos;
   logic [PW-1:0]  off;
   logic [SPW-1:0] span;
   logic [OW-1:0]  off_w;
   logic [SPW-1:0] off_cap;
   logic [PW:0]    alt_pos;
   logic [F+19:0]  step_x;
   always_comb begin
      zone_x   = XW'(act_end_ff) - XW'(act_cf_ff);
      zone_pos = {zone_x[AB-1:0], F'(0)};
      end_pos  = {act_end_ff, F'(0)};
      off      = pos_ff - zone_pos;
      span     = {act_cf_ff, F'(0)};
      off_w    = OW'(off);
      off_cap  = (off_w > OW'(span)) ? span : off_w[SPW-1:0];
      alt_pos  = (PW + 1)'({held_start_ff, F'(0)}) + (PW + 1)'(off);
      step_x   = {req_step, F'(0)};
   end

   logic           fade_ff;
   logic           wrap_ff;
   logic [PW:0]    alt_ff;
   logic [SPW-1:0] ocap_ff;
   logic [FSW-1:0] step_ff;

   always_ff @(posedge clock) begin
      if (cmd.render) begin
         fade_ff <= held_en_ff && (pos_ff >= zone_pos);
         wrap_ff <= (pos_ff >= end_pos);
         alt_ff  <= alt_pos;
         ocap_ff <= off_cap;
         step_ff <= step_x[F+19:16];
      end
   end

   // gain index divider: floor(offset * depth / span), one quotient bit a cycle
   logic [NW-1:0]  rem_ff, dsh_ff;
   logic [IW-1:0]  quo_ff;
   logic [DCW-1:0] dcnt_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         dcnt_ff <= '0;
      end else if (cmd.div_start) begin
         dcnt_ff <= DCW'(IW);
      end else if (dcnt_ff != '0) begin
         dcnt_ff <= dcnt_ff - DCW'(1);
      end
   end
   always_ff @(posedge clock) begin
      if (cmd.div_start) begin
         rem_ff <= NW'(ocap_ff) * NW'(SINE_TABLE_DEPTH);
         dsh_ff <= NW'({act_cf_ff, F'(0)}) << (IW - 1);
         quo_ff <= '0;
      end else if (dcnt_ff != '0) begin
         if (rem_ff >= dsh_ff) begin
            rem_ff <= rem_ff - dsh_ff;
            quo_ff <= {quo_ff[IW-2:0], 1'b1};
         end else begin
            quo_ff <= {quo_ff[IW-2:0], 1'b0};
         end
         dsh_ff <= dsh_ff >> 1;
      end
   end

   assign st.fade     = fade_ff;
   assign st.div_busy = (dcnt_ff != '0);

   // position state
   logic [PW:0]   pos_base;
   logic [PW+1:0] pos_next;
   always_comb begin
      pos_base = (fade_ff && wrap_ff) ? alt_ff : (PW + 1)'(pos_ff);
      pos_next = (PW + 2)'(pos_base) + (PW + 2)'(step_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff        <= '0;
         act_end_ff    <= '0;
         act_cf_ff     <= '0;
         held_start_ff <= '0;
         held_en_ff    <= 1'b0;
      end else if (cmd.note) begin
         pos_ff        <= '0;
         act_end_ff    <= note_e;
         act_cf_ff     <= note_cf;
         held_start_ff <= note_s;
         held_en_ff    <= loop_enable_ff;
      end else if (cmd.out_load) begin
         pos_ff <= (pos_next > (PW + 2)'(POS_MAX)) ? POS_MAX : pos_next[PW-1:0];
      end
   end

   // sample memories
   logic [AB+15:0]  waddr_x;
   logic [SB+15:0]  lw_x, rw_x;
   logic [AB-1:0]   raddr;
   logic [SB-1:0]   rdata_l, rdata_r;
   logic [PW:0]     sel_pos;
   logic [AB:0]     ip;
   logic signed [AB+2:0] cand;

   assign waddr_x = {AB'(0), req_address};
   assign lw_x    = {req_left_in, SB'(0)};
   assign rw_x    = {req_right_in, SB'(0)};

   always_comb begin
      sel_pos = cmd.alt ? alt_ff : (PW + 1)'(pos_ff);
      ip      = sel_pos[PW:F];
      cand    = signed'({2'b00, ip}) + signed'((AB + 3)'(cmd.tap)) - (AB + 3)'(1);
      if (cand < 0) begin
         raddr = '0;
      end else if (cand > signed'((AB + 3)'(last_idx))) begin
         raddr = last_idx;
      end else begin
         raddr = cand[AB-1:0];
      end
   end

   lcsp_ram #(.WIDTH(SB), .DEPTH(1 << AB)) u_left_ram (
      .clock (clock),
      .we    (cmd.load),
      .waddr (waddr_x[AB-1:0]),
      .wdata (lw_x[SB+15:16]),
      .raddr (raddr),
      .rdata (rdata_l)
   );

   lcsp_ram #(.WIDTH(SB), .DEPTH(1 << AB)) u_right_ram (
      .clock (clock),
      .we    (cmd.load),
      .waddr (waddr_x[AB-1:0]),
      .wdata (rw_x[SB+15:16]),
      .raddr (raddr),
      .rdata (rdata_r)
   );

   logic signed [SB-1:0] yl_ff [0:3];
   logic signed [SB-1:0] yr_ff [0:3];
   always_ff @(posedge clock) begin
      if (cmd.cap_en) begin
         yl_ff[cmd.cap_tap] <= rdata_l;
         yr_ff[cmd.cap_tap] <= rdata_r;
      end
   end

   // catmull-rom coefficients, doubled
   logic signed [W-1:0] y0, y1, y2, y3;
   logic signed [W-1:0] c3, c2, c1, c0, coef;
   always_comb begin
      if (cmd.hor_ch) begin
         y0 = W'(yr_ff[0]);
         y1 = W'(yr_ff[1]);
         y2 = W'(yr_ff[2]);
         y3 = W'(yr_ff[3]);
      end else begin
         y0 = W'(yl_ff[0]);
         y1 = W'(yl_ff[1]);
         y2 = W'(yl_ff[2]);
         y3 = W'(yl_ff[3]);
      end
      c3 = y3 - y0 + 3 * (y1 - y2);
      c2 = 2 * y0 - 5 * y1 + 4 * y2 - y3;
      c1 = y2 - y0;
      c0 = 2 * y1;
      case (cmd.hor_step)
         2'd0:    coef = c2;
         2'd1:    coef = c1;
         default: coef = c0;
      endcase
   end

   // gain table and blend gains
   logic [GAIN_BITS-1:0] gain_tab [0:SINE_TABLE_DEPTH];
   for (genvar k = 0; k <= SINE_TABLE_DEPTH; k++) begin : g_tab
      localparam logic [63:0] XK = (HALF_PI_Q30 * 64'(k)) / 64'(SINE_TABLE_DEPTH);
      assign gain_tab[k] = quarter_sine(XK);
   end

   logic [IW-1:0]        gidx;
   logic [GAIN_BITS-1:0] g_out, g_in;
   always_comb begin
      gidx = (act_cf_ff == '0) ? '0 : quo_ff;
      if (fade_ff) begin
         g_out = gain_tab[TAB_TOP - gidx];
         g_in  = gain_tab[gidx];
      end else begin
         g_out = UNITY_GAIN;
         g_in  = '0;
      end
   end

   // shared multiplier
   logic signed [W-1:0]   acc_ff;
   logic signed [W-1:0]   res_ff [0:3];
   logic signed [W-1:0]   ma;
   logic signed [MBW-1:0] mb;
   logic signed [PRW-1:0] prod, prod_sh;
   logic [F-1:0]          frac;
   logic [1:0]            bsel;

   assign frac = sel_pos[F-1:0];
   assign bsel = {cmd.blend_step[1] & stereo_ff, cmd.blend_step[0]};

   always_comb begin
      if (cmd.blend_en) begin
         // blend order: left fade-out, left fade-in, right fade-out, right fade-in
         ma = bsel[0] ? res_ff[{1'b1, bsel[1]}] : res_ff[{1'b0, bsel[1]}];
         mb = MBW'(signed'({1'b0, cmd.blend_step[0] ? g_in : g_out}));
      end else begin
         ma = (cmd.hor_step == 2'd0) ? c3 : acc_ff;
         mb = MBW'(signed'({1'b0, frac}));
      end
      prod    = ma * mb;
      prod_sh = prod >>> F;
   end

   logic signed [W-1:0] hor_sum;
   assign hor_sum = prod_sh[W-1:0] + coef;

   always_ff @(posedge clock) begin
      if (cmd.hor_en) begin
         acc_ff <= hor_sum;
         if (cmd.hor_step == 2'd2) begin
            res_ff[{cmd.alt, cmd.hor_ch}] <= hor_sum;
         end
      end
   end

   logic signed [SUMW-1:0] sl_ff, sr_ff;
   always_ff @(posedge clock) begin
      if (cmd.blend_en) begin
         case (cmd.blend_step)
            2'd0:    sl_ff <= SUMW'(prod);
            2'd1:    sl_ff <= sl_ff + SUMW'(prod);
            2'd2:    sr_ff <= SUMW'(prod);
            default: sr_ff <= sr_ff + SUMW'(prod);
         endcase
      end
   end

   // round half up, scale back to q1.15, saturate
   function automatic logic [15:0] narrow(input logic signed [SUMW-1:0] sum);
      logic signed [SUMW:0] v;
      v = ((SUMW + 1)'(sum) + ((SUMW + 1)'(1) <<< (SB - 1))) >>> SB;
      if (v > SAT_HI) begin
         return 16'h7fff;
      end else if (v < SAT_LO) begin
         return 16'h8000;
      end
      return v[15:0];
   endfunction

   logic [15:0] left_q_ff, right_q_ff;
   logic        xfade_q_ff;
   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         left_q_ff  <= narrow(sl_ff);
         right_q_ff <= narrow(sr_ff);
         xfade_q_ff <= fade_ff;
      end
   end

   assign rsp_left_out     = signed'(left_q_ff);
   assign rsp_right_out    = signed'(right_q_ff);
   assign rsp_in_crossfade = xfade_q_ff;
endmodule

// ===== rtl/core/lcsp_checker.sv =====
// port-level checks for the sample player, bound to the top level
module lcsp_checker
   import lcsp_pkg::*;
(
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_stall,
   input logic [1:0]        req_operation,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input logic signed [15:0] rsp_left_out,
   input logic signed [15:0] rsp_right_out,
   input logic              rsp_in_crossfade
);
   // a waiting result word holds until taken
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_left_out)
         && $stable(rsp_right_out) && $stable(rsp_in_crossfade))
      else $error("result word changed while stalled");

   // a result only appears at the end of a render, while input was held off
   a_rsp_after_busy: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_stall))
      else $error("result appeared without a render in progress");

   // loads and note starts never hold off the next word
   a_short_ops: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && (req_operation != OP_RENDER) |=> !req_stall)
      else $error("stall after a load or note start");
endmodule

bind looped_cubic_sample_playback lcsp_checker u_lcsp_checker (.*);
